// ----- src/rsps_pkg.sv -----
// ----------------------------------------------------------------------------
// rsps_pkg: shared types and constants for the ray-sphere path split
// Widths of the geometry pipeline and the sideband records that travel
// alongside the square-root and divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rsps_pkg;

    // field widths
    localparam int CW     = 19;   // coordinate / center z
    localparam int RW     = 18;   // radius
    localparam int LW     = 20;   // output lengths
    localparam int GUARD  = 8;    // internal guard fraction bits

    // internal datapath widths
    localparam int DW     = 20;   // coordinate differences
    localparam int PW     = 40;   // products of differences
    localparam int SUMW   = 42;   // sums of three products
    localparam int MAGW   = 40;   // |b|, d2
    localparam int RCW    = 41;   // r2 - c2, signed
    localparam int ACCW   = 60;   // remainder width of sqrt / divide
    localparam int DRFW   = 28;   // distance root
    localparam int UQW    = 30;   // projection quotient
    localparam int SQW    = 30;   // second root
    localparam int PATHW  = 32;   // path length, guard units

    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_CENTER_Z = 2'd1;

    // sideband through the distance root
    typedef struct packed {
        logic            deg;
        logic            vin;
        logic            bneg;
        logic [MAGW-1:0] babs;
        logic [RCW-1:0]  rc;
    } s1_t;

    // sideband through the divider
    typedef struct packed {
        logic            deg;
        logic            vin;
        logic            bneg;
        logic [RCW-1:0]  rc;
        logic [DRFW-1:0] drf;
    } s2_t;

    // sideband through the discriminant root
    typedef struct packed {
        logic            deg;
        logic            vin;
        logic            bneg;
        logic [UQW-1:0]  umag;
        logic [DRFW-1:0] drf;
    } s3_t;

endpackage

`default_nettype wire

// ----- src/ray_sphere_path_split.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_path_split: path length of a ray inside a sphere
// For a sensor point and a source vertex, returns the length along the ray
// from the vertex that lies inside a sphere on the z axis, and the rest of
// the vertex-to-sensor distance.
//
// Input channel s_*: one transfer per item, six signed coordinates.
// Result channel m_*: one transfer per item, in input order.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 radius, 1 center z;
// other indexes are ignored. Write only while the pipeline is empty.
// Pipeline: 3 geometry stages, 28 stages of the distance root, 30 divider
// stages, 2 discriminant stages, 30 stages of the second root and 2 output
// stages; the roots and divider give one bit per stage. One item per cycle
// is taken while the receiver keeps up. All stages share one enable: when
// the receiver holds m_ready low with a result waiting, the whole pipeline
// and s_ready hold until that result is taken; nothing is lost or repeated.
// Reset clears every valid bit and loads the default radius and center.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_path_split
    import rsps_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CW-1:0]        cfg_wdata,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [CW-1:0] s_sensor_x,
    input  wire logic signed [CW-1:0] s_sensor_y,
    input  wire logic signed [CW-1:0] s_sensor_z,
    input  wire logic signed [CW-1:0] s_source_x,
    input  wire logic signed [CW-1:0] s_source_y,
    input  wire logic signed [CW-1:0] s_source_z,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [LW-1:0]             m_inside_length,
    output logic [LW-1:0]             m_outside_length,
    output logic                      m_degenerate
);

    localparam int RADIUS_RST_FULL = 6060 << COORD_FRAC_BITS;
    localparam logic [RW-1:0] RADIUS_RST = RADIUS_RST_FULL[RW-1:0];
    localparam int S1W = $bits(s1_t);
    localparam int S3W = $bits(s3_t);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RW-1:0]        radius_reg;
    logic signed [CW-1:0] cz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            cz_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RADIUS:   radius_reg <= cfg_wdata[RW-1:0];
                CFG_CENTER_Z: cz_reg     <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage A: differences d = P - V, c = V - center
    // ------------------------------------------------------------------
    logic                 a_vld_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg, cx_reg, cy_reg, cz_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= DW'(s_sensor_x) - DW'(s_source_x);
            dy_reg   <= DW'(s_sensor_y) - DW'(s_source_y);
            dz_reg   <= DW'(s_sensor_z) - DW'(s_source_z);
            cx_reg   <= DW'(s_source_x);
            cy_reg   <= DW'(s_source_y);
            cz_d_reg <= DW'(s_source_z) - DW'(cz_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage B: products
    // ------------------------------------------------------------------
    logic                 b_vld_reg;
    logic signed [PW-1:0] dxx_reg, dyy_reg, dzz_reg;
    logic signed [PW-1:0] cxx_reg, cyy_reg, czz_reg;
    logic signed [PW-1:0] cdx_reg, cdy_reg, cdz_reg;
    logic [2*RW-1:0]      r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxx_reg <= dx_reg * dx_reg;
            dyy_reg <= dy_reg * dy_reg;
            dzz_reg <= dz_reg * dz_reg;
            cxx_reg <= cx_reg * cx_reg;
            cyy_reg <= cy_reg * cy_reg;
            czz_reg <= cz_d_reg * cz_d_reg;
            cdx_reg <= cx_reg * dx_reg;
            cdy_reg <= cy_reg * dy_reg;
            cdz_reg <= cz_d_reg * dz_reg;
            r2_reg  <= radius_reg * radius_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage C: dot products, |b|, r2 - c2
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] d2_sum, c2_sum, b_sum, rc_sum, b_abs;

    always_comb begin
        d2_sum = SUMW'(dxx_reg) + SUMW'(dyy_reg) + SUMW'(dzz_reg);
        c2_sum = SUMW'(cxx_reg) + SUMW'(cyy_reg) + SUMW'(czz_reg);
        b_sum  = SUMW'(cdx_reg) + SUMW'(cdy_reg) + SUMW'(cdz_reg);
        rc_sum = $signed({{(SUMW-2*RW){1'b0}}, r2_reg}) - c2_sum;
        b_abs  = b_sum[SUMW-1] ? -b_sum : b_sum;
    end

    logic            c_vld_reg;
    logic [MAGW-1:0] d2_reg;
    s1_t             c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg          <= d2_sum[MAGW-1:0];
            c_side_reg.deg  <= d2_sum == '0;
            c_side_reg.vin  <= rc_sum > 0;
            c_side_reg.bneg <= b_sum[SUMW-1];
            c_side_reg.babs <= b_abs[MAGW-1:0];
            c_side_reg.rc   <= rc_sum[RCW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // distance root: drf = floor(sqrt(d2 << 2G))
    // ------------------------------------------------------------------
    logic            r1_vld;
    logic [DRFW-1:0] r1_root;
    logic [S1W-1:0]  r1_side_vec;
    s1_t             r1_side;

    rsps_sqrt_pipe #(
        .W      (ACCW),
        .N      (DRFW),
        .SIDE_W (S1W)
    ) u_sqrt_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (c_vld_reg),
        .in_val   ({{(ACCW-MAGW-2*GUARD){1'b0}}, d2_reg, {(2*GUARD){1'b0}}}),
        .in_side  (c_side_reg),
        .out_vld  (r1_vld),
        .out_root (r1_root),
        .out_side (r1_side_vec)
    );

    assign r1_side = s1_t'(r1_side_vec);

    // ------------------------------------------------------------------
    // divider: umag = (|b| << 2G) / drf, one quotient bit per stage
    // ------------------------------------------------------------------
    logic            dv_vld_reg [UQW];
    logic [ACCW-1:0] dv_rem_reg [UQW];
    logic [UQW-1:0]  dv_q_reg   [UQW];
    s2_t             dv_side_reg[UQW];

    for (genvar k = 0; k < UQW; k++) begin : g_div
        localparam int B = UQW - 1 - k;
        logic            v_in;
        logic [ACCW-1:0] rem_in;
        logic [UQW-1:0]  q_in;
        s2_t             side_in;
        logic [ACCW:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign v_in         = r1_vld;
            assign rem_in       = {{(ACCW-MAGW-2*GUARD){1'b0}}, r1_side.babs,
                                   {(2*GUARD){1'b0}}};
            assign q_in         = '0;
            assign side_in.deg  = r1_side.deg;
            assign side_in.vin  = r1_side.vin;
            assign side_in.bneg = r1_side.bneg;
            assign side_in.rc   = r1_side.rc;
            assign side_in.drf  = r1_root;
        end else begin : g_next
            assign v_in    = dv_vld_reg[k-1];
            assign rem_in  = dv_rem_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign side_in = dv_side_reg[k-1];
        end

        assign trial = {{(ACCW+1-DRFW){1'b0}}, side_in.drf} << B;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[k]  <= take ? rem_in - trial[ACCW-1:0] : rem_in;
                dv_q_reg[k]    <= take ? (q_in | (UQW'(1) << B)) : q_in;
                dv_side_reg[k] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage M: umag squared
    // ------------------------------------------------------------------
    logic            m_vld_reg;
    logic [2*UQW-1:0] usq_reg;
    logic [RCW-1:0]  m_rc_reg;
    s3_t             m_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= dv_vld_reg[UQW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            usq_reg         <= dv_q_reg[UQW-1] * dv_q_reg[UQW-1];
            m_rc_reg        <= dv_side_reg[UQW-1].rc;
            m_side_reg.deg  <= dv_side_reg[UQW-1].deg;
            m_side_reg.vin  <= dv_side_reg[UQW-1].vin;
            m_side_reg.bneg <= dv_side_reg[UQW-1].bneg;
            m_side_reg.umag <= dv_q_reg[UQW-1];
            m_side_reg.drf  <= dv_side_reg[UQW-1].drf;
        end
    end

    // ------------------------------------------------------------------
    // stage Q: discriminant, clamped at zero for the root
    // ------------------------------------------------------------------
    localparam int QW = ACCW + 2;
    logic signed [QW-1:0] q_sum;

    assign q_sum = $signed({2'b00, usq_reg})
                 + ($signed(QW'($signed(m_rc_reg))) <<< (2 * GUARD));

    logic            q_vld_reg;
    logic [ACCW-1:0] q_reg;
    s3_t             q_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else if (en) begin
            q_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg      <= (q_sum > 0) ? q_sum[ACCW-1:0] : '0;
            q_side_reg <= m_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // discriminant root: s = floor(sqrt(q))
    // ------------------------------------------------------------------
    logic           r2_vld;
    logic [SQW-1:0] r2_root;
    logic [S3W-1:0] r2_side_vec;
    s3_t            r2_side;

    rsps_sqrt_pipe #(
        .W      (ACCW),
        .N      (SQW),
        .SIDE_W (S3W)
    ) u_sqrt_disc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (q_vld_reg),
        .in_val   (q_reg),
        .in_side  (q_side_reg),
        .out_vld  (r2_vld),
        .out_root (r2_root),
        .out_side (r2_side_vec)
    );

    assign r2_side = s3_t'(r2_side_vec);

    // ------------------------------------------------------------------
    // stage F: roots a1, a2 and path selection
    // ------------------------------------------------------------------
    logic signed [PATHW-1:0] uf, s_ext, a1, a2, path;

    always_comb begin
        uf    = r2_side.bneg ? -$signed(PATHW'(r2_side.umag))
                             : $signed(PATHW'(r2_side.umag));
        s_ext = $signed(PATHW'(r2_root));
        a1    = s_ext - uf;
        a2    = -s_ext - uf;
        path  = '0;
        if (r2_side.vin) begin
            // vertex inside: forward root only
            if (a1 > 0 && a2 < 0) begin
                path = a1;
            end
        end else begin
            // vertex outside: chord when both roots lie ahead
            if (a1 > 0 && a2 > 0) begin
                path = a1 - a2;
            end
        end
    end

    logic             f_vld_reg;
    logic [PATHW-1:0] f_path_reg;
    logic [DRFW-1:0]  f_drf_reg;
    logic             f_deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= r2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_path_reg <= path;
            f_drf_reg  <= r2_side.drf;
            f_deg_reg  <= r2_side.deg;
        end
    end

    // ------------------------------------------------------------------
    // stage O: rounding, saturation, output register
    // ------------------------------------------------------------------
    logic [PATHW-GUARD:0] ins_full;
    logic [DRFW-GUARD:0]  tot_full;
    logic [LW-1:0]        ins_sat, tot_sat;

    always_comb begin
        ins_full = (PATHW-GUARD+1)'(({1'b0, f_path_reg} + (PATHW+1)'(1 << (GUARD-1)))
                   >> GUARD);
        tot_full = (DRFW-GUARD+1)'(({1'b0, f_drf_reg} + (DRFW+1)'(1 << (GUARD-1)))
                   >> GUARD);
        ins_sat  = (ins_full > (PATHW-GUARD+1)'(LEN_MAX)) ? LEN_MAX : ins_full[LW-1:0];
        tot_sat  = (tot_full > (DRFW-GUARD+1)'(LEN_MAX)) ? LEN_MAX : tot_full[LW-1:0];
    end

    logic          m_valid_reg;
    logic [LW-1:0] m_ins_reg, m_out_reg;
    logic          m_deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_deg_reg <= f_deg_reg;
            if (f_deg_reg) begin
                m_ins_reg <= '0;
                m_out_reg <= '0;
            end else begin
                m_ins_reg <= ins_sat;
                m_out_reg <= (tot_sat > ins_sat) ? tot_sat - ins_sat : '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_inside_length  = m_ins_reg;
    assign m_outside_length = m_out_reg;
    assign m_degenerate     = m_deg_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_inside_length == '0 && m_outside_length == '0)
        else $error("degenerate result with nonzero length");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !f_vld_reg && !c_vld_reg)
        else $error("valid bits not cleared by reset");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(f_vld_reg) && $stable(q_vld_reg) && $stable(a_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ----- src/rsps_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// rsps_sqrt_pipe: pipelined integer square root
// One result bit per register stage, remainder form, with a sideband word
// and a valid bit carried through every stage. Stages hold while en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_sqrt_pipe #(
    parameter int W      = 60,   // radicand width, at least 2*N-1
    parameter int N      = 30,   // root width
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [W-1:0]      in_val,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    output logic [N-1:0]           out_root,
    output logic [SIDE_W-1:0]      out_side
);

    logic              vld_reg  [N];
    logic [W-1:0]      rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_st
        localparam int B = N - 1 - k;
        logic              v_in;
        logic [W-1:0]      rem_in;
        logic [N-1:0]      root_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign rem_in  = in_val;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // trial subtrahend (2r + 2^B) * 2^B
        assign trial = ({{(W+1-N){1'b0}}, root_in} << (B + 1))
                     + ((W+1)'(1) << (2 * B));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? rem_in - trial[W-1:0] : rem_in;
                root_reg[k] <= take ? (root_in | (N'(1) << B)) : root_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = root_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

`default_nettype wire
